FILE: design/cmpf_pkg.sv
package cmpf_pkg;

    // geometry of the filter
    localparam int NUM_ROWS    = 4;
    localparam int NUM_CH      = 4;
    localparam int NUM_COLOURS = 3;
    localparam int ROW_IDX_W   = 2;
    localparam int CHAN_W      = 8;

    // row and channel order: red, green, blue, alpha
    localparam int ROW_RED   = 0;
    localparam int ROW_GREEN = 1;
    localparam int ROW_BLUE  = 2;
    localparam int ROW_ALPHA = 3;

    // configuration port
    localparam int REG_W  = 64;
    localparam int IDX_W  = 3;
    localparam int SLOT_W = 16;
    localparam int GAIN_ONE = 256;

    typedef enum logic [IDX_W-1:0] {
        REG_RED_GAINS,
        REG_GREEN_GAINS,
        REG_BLUE_GAINS,
        REG_ALPHA_GAINS,
        REG_ROW_OFFSETS
    } cmpf_reg_t;

    // row sums are exact multiples of 1/(255*256), magnitude below 2^33
    localparam int ROW_W   = 35;
    localparam int MAG_W   = 34;
    localparam int HALF_W  = 17;
    localparam int PP_W    = 2 * HALF_W;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int DEN_SHIFT = 16;
    localparam int PSH_W   = PROD_W - DEN_SHIFT;

    // alpha row: clamp at 256*255*256, else (na>>8)/255 by reciprocal
    localparam logic signed [ROW_W-1:0] ALPHA_SAT = 35'sd16711680;
    localparam int A_SRC_LSB   = 8;
    localparam int A_SRC_W     = 16;
    localparam int A_PROD_W    = 32;
    localparam logic [A_SRC_W-1:0] ALPHA_RECIP = 16'd32897;
    localparam int ALPHA_RSHIFT = 23;

    // colour rows: product over 2^16 then divided by 255^3
    localparam int DIV_W          = 32;
    localparam int QUO_W          = 8;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = 2;
    localparam logic [DIV_W-1:0] DIV_CONST  = 32'd16581375;
    localparam logic [DIV_W-1:0] COLOUR_SAT = 32'd4244832000;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] alpha_in;
    } cmpf_pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] alpha_out;
    } cmpf_result_t;

    typedef logic signed [ROW_W-1:0] cmpf_row_t;

    // colour product on its way to the divider
    typedef struct packed {
        logic             kill;
        logic [PSH_W-1:0] prod;
    } cmpf_prod_t;

endpackage

FILE: design/color_matrix_pixel_filter.sv
// a request passes the matrix, alpha-scale and divider stages and the output register before done rises
// throughput: one pixel per clock, set by the fully pipelined multiply and divide stages
// busy never rises; results cannot be held off and leave on done for one cycle
// reset clears the pipeline valid bits and loads identity gains and zero offsets
module color_matrix_pixel_filter
    import cmpf_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmpf_pixel_t      pixel,
    output logic             done,
    output cmpf_result_t     result,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0] wr_data
);

    localparam int ALPHA_DLY = DIV_STAGES;

    logic signed [COEF_BITS-1:0] gain_reg [NUM_ROWS][NUM_CH];
    logic signed [SLOT_W-1:0]    offset_reg [NUM_ROWS];

    logic              accept;
    logic              mat_valid;
    cmpf_row_t         mat_row [NUM_ROWS];
    logic              scl_valid;
    cmpf_prod_t        scl_prod [NUM_COLOURS];
    logic [CHAN_W-1:0] scl_alpha;
    logic              div_valid [NUM_COLOURS];
    logic [QUO_W-1:0]  div_quo [NUM_COLOURS];

    logic [CHAN_W-1:0] alpha_dly_reg [ALPHA_DLY];
    logic              done_reg;
    cmpf_result_t      result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int k = 0; k < NUM_CH; k++)
                begin
                    gain_reg[r][k] <= (r == k) ? COEF_BITS'(GAIN_ONE) : '0;
                end
                offset_reg[r] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (cmpf_reg_t'(wr_index))
                REG_RED_GAINS, REG_GREEN_GAINS, REG_BLUE_GAINS, REG_ALPHA_GAINS:
                begin
                    for (int k = 0; k < NUM_CH; k++)
                    begin
                        gain_reg[wr_index[ROW_IDX_W-1:0]][k] <= wr_data[k*SLOT_W +: COEF_BITS];
                    end
                end
                REG_ROW_OFFSETS:
                begin
                    for (int r = 0; r < NUM_ROWS; r++)
                    begin
                        offset_reg[r] <= wr_data[r*SLOT_W +: SLOT_W];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // colour matrix rows
    cmpf_matrix #(
        .COEF_BITS (COEF_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pixel     (pixel),
        .gain      (gain_reg),
        .offset    (offset_reg),
        .out_valid (mat_valid),
        .row       (mat_row)
    );

    // alpha byte and colour-by-alpha products
    cmpf_alpha_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mat_valid),
        .row        (mat_row),
        .out_valid  (scl_valid),
        .prod       (scl_prod),
        .alpha_byte (scl_alpha)
    );

    // one divider per colour
    for (genvar c = 0; c < NUM_COLOURS; c++)
    begin : g_div
        cmpf_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (scl_valid),
            .src       (scl_prod[c]),
            .out_valid (div_valid[c]),
            .quo       (div_quo[c])
        );
    end

    // alpha byte waits for the dividers
    always_ff @(posedge clk)
    begin
        alpha_dly_reg[0] <= scl_alpha;
        for (int i = 1; i < ALPHA_DLY; i++)
        begin
            alpha_dly_reg[i] <= alpha_dly_reg[i-1];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid[ROW_RED];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.red_out   <= div_quo[ROW_RED];
        result_reg.green_out <= div_quo[ROW_GREEN];
        result_reg.blue_out  <= div_quo[ROW_BLUE];
        result_reg.alpha_out <= alpha_dly_reg[ALPHA_DLY-1];
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every request yields exactly one result on done
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##9 done)
        else $error("request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 10))
        else $error("result without a matching request");

    // colour dividers run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[ROW_RED] == div_valid[ROW_GREEN] && div_valid[ROW_RED] == div_valid[ROW_BLUE])
        else $error("colour dividers out of step");

endmodule

FILE: design/cmpf_matrix.sv
module cmpf_matrix
    import cmpf_pkg::*;
#(
    parameter int COEF_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  cmpf_pixel_t                 pixel,
    input  logic signed [COEF_BITS-1:0] gain [NUM_ROWS][NUM_CH],
    input  logic signed [SLOT_W-1:0]    offset [NUM_ROWS],
    output logic                        out_valid,
    output cmpf_row_t                   row [NUM_ROWS]
);

    localparam int MAT_STAGES = 3;
    localparam int CP_W       = 2 * CHAN_W;
    localparam int TERM_W     = COEF_BITS + CP_W + 1;
    localparam int OFS_W      = SLOT_W + 11;

    logic [MAT_STAGES-1:0]    valid_reg;
    logic [CP_W-1:0]          chan_reg [NUM_CH];
    logic signed [TERM_W-1:0] term_reg [NUM_ROWS][NUM_CH];
    logic signed [OFS_W-1:0]  ofs_reg [NUM_ROWS];
    cmpf_row_t                row_reg [NUM_ROWS];

    // valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[MAT_STAGES-2:0], in_valid};
        end
    end

    // premultiply colours by alpha, alpha by 255
    always_ff @(posedge clk)
    begin
        chan_reg[ROW_RED]   <= {8'd0, pixel.red_in} * {8'd0, pixel.alpha_in};
        chan_reg[ROW_GREEN] <= {8'd0, pixel.green_in} * {8'd0, pixel.alpha_in};
        chan_reg[ROW_BLUE]  <= {8'd0, pixel.blue_in} * {8'd0, pixel.alpha_in};
        chan_reg[ROW_ALPHA] <= {pixel.alpha_in, 8'd0} - {8'd0, pixel.alpha_in};
    end

    // gain products, offset times 1020
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                term_reg[r][k] <= gain[r][k] * $signed({1'b0, chan_reg[k]});
            end
            ofs_reg[r] <= (OFS_W'(offset[r]) <<< 10) - (OFS_W'(offset[r]) <<< 2);
        end
    end

    // row sums
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row_reg[r] <= ROW_W'(term_reg[r][0]) + ROW_W'(term_reg[r][1])
                        + ROW_W'(term_reg[r][2]) + ROW_W'(term_reg[r][3])
                        + ROW_W'(ofs_reg[r]);
        end
    end

    assign out_valid = valid_reg[MAT_STAGES-1];
    assign row       = row_reg;

endmodule

FILE: design/cmpf_alpha_scale.sv
module cmpf_alpha_scale
    import cmpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cmpf_row_t         row [NUM_ROWS],
    output logic              out_valid,
    output cmpf_prod_t        prod [NUM_COLOURS],
    output logic [CHAN_W-1:0] alpha_byte
);

    logic [1:0]            valid_reg;
    logic                  a_pos_reg;
    logic                  a_sat_reg;
    logic [A_PROD_W-1:0]   alpha_mul_reg;
    logic                  kill_reg [NUM_COLOURS];
    logic [PP_W-1:0]       pp_reg [NUM_COLOURS][4];
    cmpf_prod_t            prod_reg [NUM_COLOURS];
    logic [CHAN_W-1:0]     alpha_byte_reg;

    cmpf_row_t             na;
    logic [MAG_W-1:0]      mag_a;
    logic [MAG_W-1:0]      mag_c [NUM_COLOURS];
    logic                  kill_c [NUM_COLOURS];
    logic [PROD_W-1:0]     sum_c [NUM_COLOURS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    // signs, magnitudes and kill flags
    always_comb
    begin
        na    = row[ROW_ALPHA];
        mag_a = na[ROW_W-1] ? MAG_W'(-na) : MAG_W'(na);
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            mag_c[c]  = row[c][ROW_W-1] ? MAG_W'(-row[c]) : MAG_W'(row[c]);
            kill_c[c] = (row[c] == '0) || (na == '0) || (row[c][ROW_W-1] != na[ROW_W-1]);
        end
    end

    // partial products of colour times alpha, alpha reciprocal product
    always_ff @(posedge clk)
    begin
        a_pos_reg     <= !na[ROW_W-1] && (na != '0);
        a_sat_reg     <= na >= ALPHA_SAT;
        alpha_mul_reg <= {16'd0, na[A_SRC_LSB +: A_SRC_W]} * {16'd0, ALPHA_RECIP};
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            kill_reg[c]  <= kill_c[c];
            pp_reg[c][0] <= {17'd0, mag_c[c][HALF_W-1:0]} * {17'd0, mag_a[HALF_W-1:0]};
            pp_reg[c][1] <= {17'd0, mag_c[c][HALF_W-1:0]} * {17'd0, mag_a[MAG_W-1:HALF_W]};
            pp_reg[c][2] <= {17'd0, mag_c[c][MAG_W-1:HALF_W]} * {17'd0, mag_a[HALF_W-1:0]};
            pp_reg[c][3] <= {17'd0, mag_c[c][MAG_W-1:HALF_W]} * {17'd0, mag_a[MAG_W-1:HALF_W]};
        end
    end

    // partial product sum
    always_comb
    begin
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            sum_c[c] = PROD_W'(pp_reg[c][0])
                     + (PROD_W'(pp_reg[c][1]) << HALF_W)
                     + (PROD_W'(pp_reg[c][2]) << HALF_W)
                     + (PROD_W'(pp_reg[c][3]) << MAG_W);
        end
    end

    // drop the 2^16 part of the denominator, finish the alpha byte
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_COLOURS; c++)
        begin
            prod_reg[c].kill <= kill_reg[c];
            prod_reg[c].prod <= sum_c[c][PROD_W-1:DEN_SHIFT];
        end
        if (!a_pos_reg)
        begin
            alpha_byte_reg <= '0;
        end
        else if (a_sat_reg)
        begin
            alpha_byte_reg <= CHAN_MAX;
        end
        else
        begin
            alpha_byte_reg <= alpha_mul_reg[ALPHA_RSHIFT +: CHAN_W];
        end
    end

    assign out_valid  = valid_reg[1];
    assign prod       = prod_reg;
    assign alpha_byte = alpha_byte_reg;

endmodule

FILE: design/cmpf_div.sv
module cmpf_div
    import cmpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cmpf_prod_t        src,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo
);

    localparam int LAST = DIV_STAGES - 1;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_W-1:0]      rem_reg [DIV_STAGES];
    logic [QUO_W-1:0]      q_reg [DIV_STAGES];
    logic                  sat_reg [DIV_STAGES];
    logic                  kill_reg [DIV_STAGES];

    logic [DIV_W-1:0]      rem_nx [DIV_STAGES];
    logic [QUO_W-1:0]      q_nx [DIV_STAGES];
    logic                  sat_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    // saturation check runs beside the first division step
    assign sat_in = (src.prod[PSH_W-1:DIV_W] != '0) || (src.prod[DIV_W-1:0] >= COLOUR_SAT);

    // restoring division, two quotient bits per stage
    always_comb
    begin : div_steps
        logic [DIV_W-1:0] rem_v;
        logic [DIV_W-1:0] trial;
        logic [QUO_W-1:0] q_v;
        int               b;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_v = (s == 0) ? src.prod[DIV_W-1:0] : rem_reg[(s == 0) ? 0 : s - 1];
            q_v   = (s == 0) ? '0 : q_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                b     = QUO_W - 1 - s * BITS_PER_STAGE - j;
                trial = DIV_CONST << b;
                if (rem_v >= trial)
                begin
                    rem_v  = rem_v - trial;
                    q_v[b] = 1'b1;
                end
            end
            rem_nx[s] = rem_v;
            q_nx[s]   = q_v;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_nx[s];
            q_reg[s]   <= q_nx[s];
            sat_reg[s]  <= (s == 0) ? sat_in : sat_reg[(s == 0) ? 0 : s - 1];
            kill_reg[s] <= (s == 0) ? src.kill : kill_reg[(s == 0) ? 0 : s - 1];
        end
    end

    // sign mismatch or zero gives 0, overflow gives 255
    always_comb
    begin
        if (kill_reg[LAST])
        begin
            quo = '0;
        end
        else if (sat_reg[LAST])
        begin
            quo = CHAN_MAX;
        end
        else
        begin
            quo = q_reg[LAST];
        end
    end

    assign out_valid = valid_reg[LAST];

    // unsaturated quotient leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] && !sat_reg[LAST] |-> rem_reg[LAST] < DIV_CONST)
        else $error("divider remainder not below divisor");

endmodule
